FILE: rtl/swcc_pkg.sv
// Shared types, constants and codes of the sliding-window congestion controller.
package swcc_pkg;

    // Sequence space and window limits.
    localparam int SEQ_BITS   = 32;
    localparam int MAX_WINDOW = 32;
    localparam int LIMIT_BITS = $clog2(MAX_WINDOW + 1);

    // Field widths of the channel words.
    localparam int CMD_BITS    = 2;
    localparam int ACKNUM_BITS = 32;
    localparam int ACTION_BITS = 2;
    localparam int FIRST_BITS  = 32;
    localparam int COUNT_BITS  = 6;
    localparam int WHOLE_BITS  = 8;
    localparam int THRESH_BITS = 8;
    localparam int TOTAL_BITS  = 32;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;
    localparam int WINDOW_BITS   = 6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_THRESHOLD = 1'b1;
    localparam logic [WINDOW_BITS-1:0]  WINDOW_RESET       = 6'd5;
    localparam logic [THRESH_BITS-1:0]  THRESH_RESET       = 8'd32;

    // Congestion window in unsigned Q8.16.
    localparam int CW_BITS = 24;
    localparam logic [CW_BITS-1:0] CW_ONE = 24'h01_0000;
    localparam logic [CW_BITS-1:0] CW_MAX = 24'hFF_FFFF;
    localparam logic [THRESH_BITS-1:0] DUP_CWND_BONUS = 8'd3;

    // Duplicate ACK counter.
    localparam int DUP_BITS = 2;
    localparam logic [DUP_BITS-1:0] DUP_LIMIT = 2'd3;

    // Radix-4 restoring divider for 2^32 / cwnd.
    localparam int QUO_BITS     = 34;
    localparam int REM_BITS     = CW_BITS;
    localparam int DIV_STEPS    = QUO_BITS / 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam logic [QUO_BITS-1:0] DIV_DIVIDEND = 34'h1_0000_0000;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_NONE = 2'd0,
        ACT_SEND = 2'd1,
        ACT_RETX = 2'd2
    } t_action;

    // Operations the controller asks of the datapath.
    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_EVAL,
        OP_SEND,
        OP_NONE,
        OP_ACK_SS,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ACK_AVOID,
        OP_DUP,
        OP_TIMEOUT,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_cmd cmd;
        logic grant_ok;
        logic ack_ok;
        logic dup_hit;
        logic any_outst;
        logic avoid_phase;
    } t_dp_status;

endpackage

FILE: rtl/swcc_in_if.sv
// Request channel: one event word per handshake.
interface swcc_in_if import swcc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_BITS-1:0]    command;
    logic [ACKNUM_BITS-1:0] ack_number;
    logic                   peer_window_open;

    modport source (output valid, command, ack_number, peer_window_open, input ready);
    modport sink   (input valid, command, ack_number, peer_window_open, output ready);
endinterface

FILE: rtl/swcc_out_if.sv
// Result channel: one decision word per handshake.
interface swcc_out_if import swcc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [FIRST_BITS-1:0]  first_sequence;
    logic [COUNT_BITS-1:0]  range_count;
    logic [COUNT_BITS-1:0]  newly_acked;
    logic [WHOLE_BITS-1:0]  window_whole;
    logic [THRESH_BITS-1:0] threshold_now;
    logic                   phase;

    modport source (output valid, action, first_sequence, range_count, newly_acked,
                    window_whole, threshold_now, phase, input ready);
    modport sink   (input valid, action, first_sequence, range_count, newly_acked,
                    window_whole, threshold_now, phase, output ready);
endinterface

FILE: rtl/swcc_ctrl.sv
// Controller state machine: sequences each event word through the datapath.
module swcc_ctrl import swcc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_op        o_op
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EVAL    = 6'b000010,
        S_DECIDE  = 6'b000100,
        S_DIVIDE  = 6'b001000,
        S_AVOID   = 6'b010000,
        S_PUBLISH = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [DIV_CNT_BITS-1:0] r_div_cnt, n_div_cnt;
    logic                    r_out_valid, n_out_valid;
    t_op                     op;

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid;
        op          = OP_HOLD;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                op      = OP_EVAL;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_PUBLISH;
                unique case (i_status.cmd)
                    CMD_SEND: begin
                        op = i_status.grant_ok ? OP_SEND : OP_NONE;
                    end
                    CMD_ACK: begin
                        if (i_status.ack_ok) begin
                            if (i_status.avoid_phase) begin
                                op        = OP_DIV_START;
                                n_div_cnt = '0;
                                n_state   = S_DIVIDE;
                            end else begin
                                op = OP_ACK_SS;
                            end
                        end else if (i_status.dup_hit) begin
                            op = OP_DUP;
                        end else begin
                            op = OP_NONE;
                        end
                    end
                    CMD_TIMEOUT: begin
                        op = i_status.any_outst ? OP_TIMEOUT : OP_NONE;
                    end
                    CMD_UNUSED: begin
                        op = OP_NONE;
                    end
                endcase
            end
            S_DIVIDE: begin
                op = OP_DIV_STEP;
                if (r_div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = S_AVOID;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_AVOID: begin
                op      = OP_ACK_AVOID;
                n_state = S_PUBLISH;
            end
            S_PUBLISH: begin
                // The result register frees up in the same cycle it is taken.
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_PUBLISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_op        = op;

endmodule

FILE: rtl/swcc_dp.sv
// Datapath: window state, congestion state, radix-4 divider and result register.
module swcc_dp import swcc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_op                      i_op,
    output t_dp_status               o_status,
    input  logic [CMD_BITS-1:0]      i_command,
    input  logic [ACKNUM_BITS-1:0]   i_ack_number,
    input  logic                     i_peer_window_open,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic [ACTION_BITS-1:0]   o_action,
    output logic [FIRST_BITS-1:0]    o_first_sequence,
    output logic [COUNT_BITS-1:0]    o_range_count,
    output logic [COUNT_BITS-1:0]    o_newly_acked,
    output logic [WHOLE_BITS-1:0]    o_window_whole,
    output logic [THRESH_BITS-1:0]   o_threshold_now,
    output logic                     o_phase
);

    // Architectural state.
    logic [SEQ_BITS-1:0]    r_next, n_next;
    logic [SEQ_BITS-1:0]    r_oldest, n_oldest;
    logic [CW_BITS-1:0]     r_cwnd, n_cwnd;
    logic [THRESH_BITS-1:0] r_ssthresh, n_ssthresh;
    logic                   r_phase, n_phase;
    logic [DUP_BITS-1:0]    r_dup, n_dup;
    logic                   r_peer_open, n_peer_open;
    logic [TOTAL_BITS-1:0]  r_acked_total, n_acked_total;
    logic [WINDOW_BITS-1:0] r_window, n_window;

    // Per-word working registers.
    t_cmd                   r_cmd, n_cmd;
    logic [SEQ_BITS-1:0]    r_ack, n_ack;
    logic                   r_pwo, n_pwo;
    logic [SEQ_BITS-1:0]    r_outst, n_outst;
    logic [SEQ_BITS-1:0]    r_dist, n_dist;
    logic                   r_dup_match, n_dup_match;
    logic [LIMIT_BITS-1:0]  r_limit, n_limit;
    logic [REM_BITS-1:0]    r_rem, n_rem;
    logic [QUO_BITS-1:0]    r_quo, n_quo;
    logic [CW_BITS-1:0]     r_divisor, n_divisor;
    t_action                r_res_action, n_res_action;
    logic [SEQ_BITS-1:0]    r_res_first, n_res_first;
    logic [COUNT_BITS-1:0]  r_res_count, n_res_count;
    logic [COUNT_BITS-1:0]  r_res_newly, n_res_newly;

    // Result register.
    t_action                r_out_action, n_out_action;
    logic [FIRST_BITS-1:0]  r_out_first, n_out_first;
    logic [COUNT_BITS-1:0]  r_out_count, n_out_count;
    logic [COUNT_BITS-1:0]  r_out_newly, n_out_newly;
    logic [WHOLE_BITS-1:0]  r_out_whole, n_out_whole;
    logic [THRESH_BITS-1:0] r_out_thresh, n_out_thresh;
    logic                   r_out_phase, n_out_phase;

    // Combinational helpers.
    logic [7:0]             win_cap;
    logic [7:0]             limit_full;
    logic [REM_BITS:0]      div_t1, div_t2;
    logic                   div_b1, div_b2;
    logic [REM_BITS-1:0]    div_r1, div_r2;
    logic [CW_BITS:0]       ss_sum;
    logic [QUO_BITS:0]      avoid_sum;
    logic [THRESH_BITS-1:0] cwnd_half;
    logic [DUP_BITS-1:0]    dup_inc;
    logic                   do_ack;

    assign cwnd_half = {1'b0, r_cwnd[CW_BITS-1:17]};
    assign dup_inc   = r_dup + 1'b1;
    assign ss_sum    = {1'b0, r_cwnd} + {1'b0, CW_ONE};
    assign avoid_sum = {{(QUO_BITS - CW_BITS + 1){1'b0}}, r_cwnd} + {1'b0, r_quo};

    // Send limit is min(floor(cwnd), min(window, MAX_WINDOW)).
    always_comb begin
        win_cap    = ({2'b00, r_window} > 8'(MAX_WINDOW)) ? 8'(MAX_WINDOW)
                                                          : {2'b00, r_window};
        limit_full = (r_cwnd[CW_BITS-1:16] < win_cap) ? r_cwnd[CW_BITS-1:16] : win_cap;
    end

    // Two quotient bits per step of the restoring divider.
    always_comb begin
        div_t1 = {r_rem, r_quo[QUO_BITS-1]};
        div_b1 = (div_t1 >= {1'b0, r_divisor});
        div_r1 = div_b1 ? REM_BITS'(div_t1 - {1'b0, r_divisor}) : div_t1[REM_BITS-1:0];
        div_t2 = {div_r1, r_quo[QUO_BITS-2]};
        div_b2 = (div_t2 >= {1'b0, r_divisor});
        div_r2 = div_b2 ? REM_BITS'(div_t2 - {1'b0, r_divisor}) : div_t2[REM_BITS-1:0];
    end

    always_comb begin
        o_status.cmd         = r_cmd;
        o_status.grant_ok    = (r_outst < SEQ_BITS'(r_limit)) && r_peer_open;
        o_status.ack_ok      = (r_dist < r_outst) && (r_dist < SEQ_BITS'(r_limit));
        o_status.dup_hit     = r_dup_match;
        o_status.any_outst   = (r_outst != '0);
        o_status.avoid_phase = r_phase;
    end

    always_comb begin
        n_next        = r_next;
        n_oldest      = r_oldest;
        n_cwnd        = r_cwnd;
        n_ssthresh    = r_ssthresh;
        n_phase       = r_phase;
        n_dup         = r_dup;
        n_peer_open   = r_peer_open;
        n_acked_total = r_acked_total;
        n_window      = r_window;
        n_cmd         = r_cmd;
        n_ack         = r_ack;
        n_pwo         = r_pwo;
        n_outst       = r_outst;
        n_dist        = r_dist;
        n_dup_match   = r_dup_match;
        n_limit       = r_limit;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_divisor     = r_divisor;
        n_res_action  = r_res_action;
        n_res_first   = r_res_first;
        n_res_count   = r_res_count;
        n_res_newly   = r_res_newly;
        n_out_action  = r_out_action;
        n_out_first   = r_out_first;
        n_out_count   = r_out_count;
        n_out_newly   = r_out_newly;
        n_out_whole   = r_out_whole;
        n_out_thresh  = r_out_thresh;
        n_out_phase   = r_out_phase;
        do_ack        = 1'b0;

        unique case (i_op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_cmd = t_cmd'(i_command);
                n_ack = i_ack_number[SEQ_BITS-1:0];
                n_pwo = i_peer_window_open;
            end
            OP_EVAL: begin
                n_outst     = r_next - r_oldest;
                n_dist      = r_ack - r_oldest;
                n_dup_match = ((r_ack + 1'b1) == r_oldest);
                n_limit     = LIMIT_BITS'(limit_full);
                if (r_cmd == CMD_ACK) begin
                    n_peer_open = r_pwo;
                end
            end
            OP_SEND: begin
                n_res_action = ACT_SEND;
                n_res_first  = r_next;
                n_res_count  = COUNT_BITS'(1);
                n_res_newly  = '0;
                n_next       = r_next + 1'b1;
            end
            OP_NONE: begin
                n_res_action = ACT_NONE;
                n_res_first  = '0;
                n_res_count  = '0;
                n_res_newly  = '0;
            end
            OP_ACK_SS: begin
                do_ack = 1'b1;
                if (r_cwnd <= {r_ssthresh, 16'h0000}) begin
                    n_cwnd = ss_sum[CW_BITS] ? CW_MAX : ss_sum[CW_BITS-1:0];
                end else begin
                    n_phase = 1'b1;
                end
            end
            OP_DIV_START: begin
                n_rem     = '0;
                n_quo     = DIV_DIVIDEND;
                n_divisor = r_cwnd;
            end
            OP_DIV_STEP: begin
                n_rem = div_r2;
                n_quo = {r_quo[QUO_BITS-3:0], div_b1, div_b2};
            end
            OP_ACK_AVOID: begin
                // A zero divisor yields an all-ones quotient, which saturates too.
                do_ack = 1'b1;
                n_cwnd = (avoid_sum > (QUO_BITS + 1)'(CW_MAX)) ? CW_MAX
                                                              : avoid_sum[CW_BITS-1:0];
            end
            OP_DUP: begin
                n_res_action = ACT_NONE;
                n_res_first  = '0;
                n_res_count  = '0;
                n_res_newly  = '0;
                if (dup_inc == DUP_LIMIT) begin
                    n_dup = '0;
                    if (r_outst != '0) begin
                        n_res_action = ACT_RETX;
                        n_res_first  = r_oldest;
                        n_res_count  = COUNT_BITS'(r_outst);
                    end
                    if (!r_phase) begin
                        n_ssthresh = cwnd_half;
                        n_cwnd     = {cwnd_half + DUP_CWND_BONUS, 16'h0000};
                        n_phase    = 1'b1;
                    end
                end else begin
                    n_dup = dup_inc;
                end
            end
            OP_TIMEOUT: begin
                n_res_action = ACT_RETX;
                n_res_first  = r_oldest;
                n_res_count  = COUNT_BITS'(r_outst);
                n_res_newly  = '0;
                n_ssthresh   = cwnd_half;
                n_cwnd       = CW_ONE;
                n_phase      = 1'b0;
                n_dup        = '0;
            end
            OP_PUBLISH: begin
                n_out_action = r_res_action;
                n_out_first  = FIRST_BITS'(r_res_first);
                n_out_count  = r_res_count;
                n_out_newly  = r_res_newly;
                n_out_whole  = r_cwnd[CW_BITS-1:16];
                n_out_thresh = r_ssthresh;
                n_out_phase  = r_phase;
            end
            default: begin
            end
        endcase

        // Cumulative acknowledgment, shared by both growth modes.
        if (do_ack) begin
            n_res_action  = ACT_NONE;
            n_res_first   = '0;
            n_res_count   = '0;
            n_res_newly   = COUNT_BITS'(r_dist + 1'b1);
            n_acked_total = r_acked_total + TOTAL_BITS'(r_dist) + 1'b1;
            n_oldest      = r_ack + 1'b1;
            n_dup         = '0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE:    n_window   = i_cfg_data[WINDOW_BITS-1:0];
                CFG_INIT_THRESHOLD: n_ssthresh = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next        <= '0;
            r_oldest      <= '0;
            r_cwnd        <= CW_ONE;
            r_ssthresh    <= THRESH_RESET;
            r_phase       <= 1'b0;
            r_dup         <= '0;
            r_peer_open   <= 1'b1;
            r_acked_total <= '0;
            r_window      <= WINDOW_RESET;
        end else begin
            r_next        <= n_next;
            r_oldest      <= n_oldest;
            r_cwnd        <= n_cwnd;
            r_ssthresh    <= n_ssthresh;
            r_phase       <= n_phase;
            r_dup         <= n_dup;
            r_peer_open   <= n_peer_open;
            r_acked_total <= n_acked_total;
            r_window      <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ack        <= n_ack;
        r_pwo        <= n_pwo;
        r_outst      <= n_outst;
        r_dist       <= n_dist;
        r_dup_match  <= n_dup_match;
        r_limit      <= n_limit;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_divisor    <= n_divisor;
        r_res_action <= n_res_action;
        r_res_first  <= n_res_first;
        r_res_count  <= n_res_count;
        r_res_newly  <= n_res_newly;
        r_out_action <= n_out_action;
        r_out_first  <= n_out_first;
        r_out_count  <= n_out_count;
        r_out_newly  <= n_out_newly;
        r_out_whole  <= n_out_whole;
        r_out_thresh <= n_out_thresh;
        r_out_phase  <= n_out_phase;
    end

    assign o_action         = r_out_action;
    assign o_first_sequence = r_out_first;
    assign o_range_count    = r_out_count;
    assign o_newly_acked    = r_out_newly;
    assign o_window_whole   = r_out_whole;
    assign o_threshold_now  = r_out_thresh;
    assign o_phase          = r_out_phase;

endmodule

FILE: rtl/sliding_window_congestion_control_top.sv
// Top level of the sliding-window sender with Reno-style congestion control.
//
//   Channel   Dir  Handshake      Word
//   i_req     in   valid/ready    command, ack_number, peer_window_open
//   o_rsp     out  valid/ready    action, first_sequence, range_count, newly_acked,
//                                 window_whole, threshold_now, phase
//   i_cfg_*   in   write enable   register index, 8-bit data
//
// A send, timeout, duplicate or slow-start ACK word passes from acceptance through
// the EVAL, DECIDE and PUBLISH states; an ACK in congestion avoidance also runs the
// 17-step radix-4 divider that forms 2^32 / cwnd and the AVOID state before PUBLISH.
// Reset is synchronous and active low; it loads window 5, threshold 32, cwnd 1.0.
// One word is processed at a time; the result register lets the next word be
// accepted while the previous result waits on o_rsp.ready.
module sliding_window_congestion_control_top import swcc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    swcc_in_if.sink                  i_req,
    swcc_out_if.source               o_rsp,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_op        op;
    t_dp_status status;
    logic       in_ready;
    logic       out_valid;

    swcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_op        (op)
    );

    swcc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .o_status           (status),
        .i_command          (i_req.command),
        .i_ack_number       (i_req.ack_number),
        .i_peer_window_open (i_req.peer_window_open),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_action           (o_rsp.action),
        .o_first_sequence   (o_rsp.first_sequence),
        .o_range_count      (o_rsp.range_count),
        .o_newly_acked      (o_rsp.newly_acked),
        .o_window_whole     (o_rsp.window_whole),
        .o_threshold_now    (o_rsp.threshold_now),
        .o_phase            (o_rsp.phase)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // Words are taken one at a time, never in consecutive cycles.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted in two consecutive cycles");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.action == ACT_NONE)) |->
        ((o_rsp.first_sequence == '0) && (o_rsp.range_count == '0)))
        else $error("no-action result carries a sequence range");

    a_ack_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.newly_acked != '0)) |-> (o_rsp.action == ACT_NONE))
        else $error("acknowledging result also requests a transmission");

    a_range_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.range_count <= COUNT_BITS'(MAX_WINDOW)))
        else $error("retransmit range exceeds the window limit");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window sender with Reno-style congestion control.
module testbench;
    import swcc_pkg::*;

    typedef struct {
        t_cmd                   cmd;
        logic [ACKNUM_BITS-1:0] ack_number;
        logic                   peer_window_open;
        int unsigned            gap;
    } t_event;

    typedef struct {
        t_action                action;
        logic [FIRST_BITS-1:0]  first_sequence;
        logic [COUNT_BITS-1:0]  range_count;
        logic [COUNT_BITS-1:0]  newly_acked;
        logic [WHOLE_BITS-1:0]  window_whole;
        logic [THRESH_BITS-1:0] threshold_now;
        logic                   phase;
    } t_decision;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    swcc_in_if  req_if();
    swcc_out_if rsp_if();

    sliding_window_congestion_control_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sender state as the block should hold it.
    logic [WINDOW_BITS-1:0] win_limit_reg;
    logic [SEQ_BITS-1:0]    next_seq;
    logic [SEQ_BITS-1:0]    oldest_seq;
    logic [CW_BITS-1:0]     cwnd;
    logic [THRESH_BITS-1:0] ssthresh;
    logic                   avoiding;
    logic [DUP_BITS-1:0]    dup_acks;
    logic                   peer_open;

    t_event      events_pending[$];
    t_decision   decisions_due[$];
    t_event      on_wire;
    t_decision   want;
    logic        req_live;
    logic        rsp_live;
    bit          no_idle;
    int unsigned idle_count;
    int unsigned stall_left;
    int unsigned dup_left;
    int unsigned errors;
    int unsigned words_in;
    int unsigned granted_sends;
    int unsigned acks_taken;
    int unsigned retransmits;
    int unsigned avoid_entries;
    logic [WHOLE_BITS-1:0] peak_whole;

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [SEQ_BITS-1:0] in_flight();
        return next_seq - oldest_seq;
    endfunction

    // Packets allowed in flight: min(floor(cwnd), window), window capped at MAX_WINDOW.
    function automatic logic [7:0] send_cap();
        logic [7:0] w;
        w = (win_limit_reg > MAX_WINDOW) ? 8'(MAX_WINDOW) : 8'(win_limit_reg);
        return (cwnd[CW_BITS-1:16] < w) ? cwnd[CW_BITS-1:16] : w;
    endfunction

    function automatic logic [CW_BITS-1:0] cwnd_plus(logic [CW_BITS-1:0] cw, logic [33:0] inc);
        logic [34:0] sum;
        sum = 35'(cw) + 35'(inc);
        return (sum > CW_MAX) ? CW_MAX : sum[CW_BITS-1:0];
    endfunction

    function automatic t_decision advance_sender(t_event ev);
        t_decision           dec;
        logic [SEQ_BITS-1:0] outst;
        logic [SEQ_BITS-1:0] ack_off;
        outst = in_flight();
        ack_off = ev.ack_number - oldest_seq;
        dec.action = ACT_NONE;
        dec.first_sequence = '0;
        dec.range_count = '0;
        dec.newly_acked = '0;
        case (ev.cmd)
            CMD_SEND: begin
                if (outst < send_cap() && peer_open) begin
                    dec.action = ACT_SEND;
                    dec.first_sequence = next_seq;
                    dec.range_count = COUNT_BITS'(1);
                    next_seq = next_seq + 1;
                    granted_sends++;
                end
            end
            CMD_ACK: begin
                peer_open = ev.peer_window_open;
                if (ack_off < outst && ack_off < send_cap()) begin
                    if (!avoiding) begin
                        if (cwnd <= {ssthresh, 16'h0000}) begin
                            cwnd = cwnd_plus(cwnd, CW_ONE);
                        end else begin
                            avoiding = 1'b1;
                            avoid_entries++;
                        end
                    end else begin
                        cwnd = cwnd_plus(cwnd, DIV_DIVIDEND / cwnd);
                    end
                    dec.newly_acked = COUNT_BITS'(ack_off + 1);
                    oldest_seq = ev.ack_number + 1;
                    dup_acks = '0;
                    acks_taken++;
                end else if (ev.ack_number == oldest_seq - 1) begin
                    dup_acks = dup_acks + 1'b1;
                    if (dup_acks == DUP_LIMIT) begin
                        dup_acks = '0;
                        if (outst != 0) begin
                            dec.action = ACT_RETX;
                            dec.first_sequence = oldest_seq;
                            dec.range_count = outst[COUNT_BITS-1:0];
                            retransmits++;
                        end
                        // Fast recovery halves the threshold only when leaving slow start.
                        if (!avoiding) begin
                            ssthresh = {1'b0, cwnd[CW_BITS-1:17]};
                            cwnd = {ssthresh + DUP_CWND_BONUS, 16'h0000};
                            avoiding = 1'b1;
                            avoid_entries++;
                        end
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (outst != 0) begin
                    dec.action = ACT_RETX;
                    dec.first_sequence = oldest_seq;
                    dec.range_count = outst[COUNT_BITS-1:0];
                    ssthresh = {1'b0, cwnd[CW_BITS-1:17]};
                    cwnd = CW_ONE;
                    avoiding = 1'b0;
                    dup_acks = '0;
                    retransmits++;
                end
            end
            default: ;
        endcase
        dec.window_whole = cwnd[CW_BITS-1:16];
        dec.threshold_now = ssthresh;
        dec.phase = avoiding;
        if (cwnd[CW_BITS-1:16] > peak_whole)
            peak_whole = cwnd[CW_BITS-1:16];
        return dec;
    endfunction

    function automatic void compare_field(string what, logic [31:0] exp_val, logic [31:0] got);
        if (exp_val !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_val, got);
            errors++;
        end
    endfunction

    // Request driver: launches the next pending word after its drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            idle_count = 0;
        end else begin
            req_live = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                decisions_due.push_back(advance_sender(on_wire));
                words_in++;
                req_live = 1'b0;
            end
            if (!req_live && events_pending.size() != 0) begin
                if (idle_count < events_pending[0].gap) begin
                    idle_count++;
                end else begin
                    on_wire = events_pending.pop_front();
                    req_if.command <= on_wire.cmd;
                    req_if.ack_number <= on_wire.ack_number;
                    req_if.peer_window_open <= on_wire.peer_window_open;
                    req_live = 1'b1;
                    idle_count = 0;
                end
            end
            req_if.valid <= req_live;
        end
    end

    // Result monitor: checks each accepted word, then stalls for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            rsp_live = rsp_if.ready;
            if (rsp_if.valid && rsp_if.ready) begin
                if (decisions_due.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, got action %0d",
                             $time, rsp_if.action);
                    errors++;
                end else begin
                    want = decisions_due.pop_front();
                    compare_field("action", want.action, rsp_if.action);
                    compare_field("first_sequence", want.first_sequence, rsp_if.first_sequence);
                    compare_field("range_count", want.range_count, rsp_if.range_count);
                    compare_field("newly_acked", want.newly_acked, rsp_if.newly_acked);
                    compare_field("window_whole", want.window_whole, rsp_if.window_whole);
                    compare_field("threshold_now", want.threshold_now, rsp_if.threshold_now);
                    compare_field("phase", want.phase, rsp_if.phase);
                end
                stall_left = draw_wait();
                rsp_live = 1'b0;
            end
            if (!rsp_live) begin
                if (stall_left == 0)
                    rsp_live = 1'b1;
                else
                    stall_left--;
            end
            rsp_if.ready <= rsp_live;
        end
    end

    // Waits until the previous word has been accepted, so the sender state is current.
    task automatic await_turn();
        @(negedge i_clk);
        while (events_pending.size() != 0 || req_if.valid)
            @(negedge i_clk);
    endtask

    task automatic await_drain();
        await_turn();
        while (decisions_due.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic void push_event(t_cmd cmd, logic [ACKNUM_BITS-1:0] ack, logic pwo);
        t_event ev;
        ev.cmd = cmd;
        ev.ack_number = ack;
        ev.peer_window_open = pwo;
        ev.gap = draw_wait();
        events_pending.push_back(ev);
    endfunction

    task automatic send_event(t_cmd cmd, logic [ACKNUM_BITS-1:0] ack, logic pwo);
        await_turn();
        push_event(cmd, ack, pwo);
    endtask

    task automatic write_config(logic [WINDOW_BITS-1:0] win, logic [THRESH_BITS-1:0] thr);
        await_drain();
        repeat (30) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WINDOW_SIZE;
        i_cfg_data <= CFG_DATA_BITS'(win);
        @(posedge i_clk);
        i_cfg_index <= CFG_INIT_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_limit_reg = win;
        ssthresh = thr;
    endtask

    // One word drawn from the current sender state: mostly well-formed sends and
    // ACKs, with duplicate bursts, timeouts and random noise mixed in.
    task automatic random_event(bit lossless, int unsigned noise_pct);
        logic [SEQ_BITS-1:0] outst;
        logic [SEQ_BITS-1:0] ack_off;
        int unsigned         roll;
        await_turn();
        if (!lossless && $urandom_range(0, 39) == 0)
            await_drain();
        outst = in_flight();
        roll = $urandom_range(0, 99);
        if (dup_left != 0) begin
            dup_left--;
            push_event(CMD_ACK, oldest_seq - 1, 1'b1);
        end else if ($urandom_range(0, 99) < noise_pct) begin
            push_event(t_cmd'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
        end else if (!lossless && roll < 4) begin
            push_event(CMD_TIMEOUT, $urandom, 1'($urandom_range(0, 1)));
        end else if (!lossless && roll < 9) begin
            // Mostly a full triple; sometimes the burst is cut short.
            dup_left = ($urandom_range(0, 4) == 0) ? 1 : 2;
            push_event(CMD_ACK, oldest_seq - 1, 1'b1);
        end else if (!peer_open && outst == 0) begin
            push_event(CMD_ACK, $urandom, 1'b1);
        end else if (outst != 0 && (roll >= 55 || outst >= send_cap() || !peer_open)) begin
            if ($urandom_range(0, 3) == 0)
                ack_off = $urandom_range(0, outst - 1);
            else
                ack_off = $urandom_range(0, (outst > 4) ? 3 : outst - 1);
            if (!lossless && $urandom_range(0, 9) == 0)
                ack_off = outst;
            push_event(CMD_ACK, oldest_seq + ack_off,
                       lossless ? 1'b1 : 1'($urandom_range(0, 9) != 0));
        end else begin
            push_event(CMD_SEND, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(logic [WINDOW_BITS-1:0] win, logic [THRESH_BITS-1:0] thr,
                             int unsigned count, bit lossless, int unsigned noise_pct,
                             bit calm);
        write_config(win, thr);
        no_idle = calm;
        dup_left = 0;
        repeat (count) random_event(lossless, noise_pct);
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.command = '0;
        req_if.ack_number = '0;
        req_if.peer_window_open = 1'b0;
        rsp_if.ready = 1'b0;
        win_limit_reg = WINDOW_RESET;
        next_seq = '0;
        oldest_seq = '0;
        cwnd = CW_ONE;
        ssthresh = THRESH_RESET;
        avoiding = 1'b0;
        dup_acks = '0;
        peer_open = 1'b1;
        peak_whole = '0;
        no_idle = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Three duplicates of the wrapped sequence number with nothing in flight:
        // the control state still moves to avoidance, but nothing is resent.
        repeat (3) send_event(CMD_ACK, 32'hFFFF_FFFF, 1'b1);
        send_event(CMD_TIMEOUT, 32'h0000_0000, 1'b0);
        send_event(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
        // The fourth send hits the congestion window.
        repeat (4) send_event(CMD_SEND, 32'h0000_0000, 1'b0);
        send_event(CMD_ACK, 32'hFFFF_FFF0, 1'b0);
        send_event(CMD_SEND, 32'h0000_0000, 1'b1);
        // An ACK for data never sent is ignored but reopens the peer window.
        send_event(CMD_ACK, 32'd3, 1'b1);
        send_event(CMD_ACK, 32'd0, 1'b1);
        repeat (3) send_event(CMD_ACK, 32'd0, 1'b1);
        send_event(CMD_TIMEOUT, 32'hFFFF_FFFF, 1'b1);
        // With cwnd back at one, an ACK two packets ahead lies outside the window.
        send_event(CMD_ACK, 32'd2, 1'b1);
        send_event(CMD_ACK, 32'd1, 1'b1);
        send_event(CMD_SEND, 32'hFFFF_FFFF, 1'b1);
        send_event(CMD_ACK, 32'd3, 1'b1);
        send_event(CMD_SEND, 32'h0000_0000, 1'b0);
        send_event(CMD_TIMEOUT, 32'h0000_0000, 1'b0);

        // Long clean slow start up to the saturated window.
        run_phase(6'd32, 8'd255, 620, 1'b1, 0, 1'b0);
        run_phase(6'd0, 8'd0, 60, 1'b0, 20, 1'b0);
        run_phase(6'd63, 8'd1, 300, 1'b0, 5, 1'b1);
        run_phase(6'd4, 8'd255, 240, 1'b0, 5, 1'b0);
        repeat (4)
            run_phase(WINDOW_BITS'($urandom_range(4, 32)), THRESH_BITS'($urandom_range(1, 255)),
                      100, 1'b0, 10, 1'b0);

        await_drain();
        repeat (40) @(posedge i_clk);
        $display("Checked %0d words: %0d sends granted, %0d ACKs taken, %0d retransmits.",
                 words_in, granted_sends, acks_taken, retransmits);
        $display("Avoidance entered %0d times; largest congestion window %0d packets.",
                 avoid_entries, peak_whole);
        if (errors == 0 && decisions_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
